// ===== design/rbei_pkg.sv =====
// Shared constants, widths and rounding and saturation helpers for the rigid body integrator.
package rbei_pkg;

  // Lane formats
  localparam int VL              = 21;         // vector lane width, Q10.10
  localparam int QL              = 16;         // quaternion lane width, Q1.14
  localparam int VF              = 10;
  localparam int QF              = QL - 2;
  localparam int SF              = 16;         // step fraction bits
  localparam int STEP_W          = 16;
  localparam int DAMP_W          = 16;
  localparam int DAMP_SHIFT      = 24;
  localparam int HALF_STEP_SHIFT = VF + SF + 1;
  localparam int TINY_LOG2       = 20;

  localparam int VEC_BITS  = 3 * VL;
  localparam int QUAT_BITS = 4 * QL;

  // Intermediate widths
  localparam int GS_W  = VL + STEP_W + 1;      // lane times step
  localparam int LF_W  = 2 * DAMP_W + 2;       // damping factor, signed
  localparam int V1_W  = VL + 2;
  localparam int VP_W  = V1_W + LF_W;
  localparam int WP_W  = VL + LF_W;
  localparam int QP_W  = VL + QL;
  localparam int D_W   = QP_W + 2;
  localparam int DS_W  = D_W + STEP_W + 1;
  localparam int QN_W  = DS_W - HALF_STEP_SHIFT + 1;
  localparam int SQ_W  = 2 * QN_W;
  localparam int N2_W  = 64;
  localparam int NORM_LOG2 = 60;
  localparam int E_MAX = NORM_LOG2 / 2;
  localparam int E_W   = $clog2(E_MAX + 1);
  localparam int RT_W  = N2_W / 2;             // square root bits
  localparam int QT_W  = QF + 2;               // quotient bits
  localparam int NUM_W = RT_W - 1 + QF + 1;    // dividend bits
  localparam int DREM_W = RT_W + 1;

  localparam logic [N2_W-1:0] TINY_LIMIT = N2_W'(1) << (2 * QF - TINY_LOG2);

  // Pipeline depth: 11 arithmetic stages, root, divider set-up, divider, output
  localparam int PIPE_DEPTH = 11 + RT_W + 1 + QT_W + 1;

  // Stream packing
  localparam int IN_FIELD_BITS  = 3 * VEC_BITS + QUAT_BITS + 2 * DAMP_W;
  localparam int IN_DATA_W      = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 3 * VEC_BITS + QUAT_BITS;
  localparam int OUT_DATA_W     = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Configuration registers
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = VEC_BITS;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_VECTOR = CFG_IDX_W'(1);
  localparam logic [STEP_W-1:0]    STEP_RESET         = STEP_W'(1092);

  // Values carried down the normalisation tail
  typedef struct packed {
    logic                     dyn;
    logic                     satf;
    logic                     tiny;
    logic [E_W-1:0]           e;
    logic [3*VEC_BITS-1:0]    vout;
    logic [3:0][QN_W-1:0]     qn;
  } carry_t;

  // Shift right by n, rounding to nearest with ties away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                   input int unsigned n);
    logic [63:0] mag;
    logic [63:0] r;
    mag = x[63] ? (64'd0 - x) : x;
    r   = (mag + (64'd1 << (n - 1))) >> n;
    return x[63] ? $signed(64'd0 - r) : $signed(r);
  endfunction

  // Clip to a signed range of the given width
  function automatic logic signed [63:0] sat_to(input logic signed [63:0] x,
                                                input int unsigned bits);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = $signed((64'd1 << (bits - 1)) - 64'd1);
    lo = -hi - 64'sd1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

endpackage

// ===== design/rigid_body_euler_integrator_unit.sv =====
// Rigid body integrator: one body per cycle, fully pipelined.
// Throughput: one body per cycle; the pipeline advances whenever the output
// register is empty or being taken. Depth is set by the bit-per-stage square
// root (32 stages) and quotient (16 stages) of the quaternion normalisation.
// Reset (synchronous) clears all valid bits; step_time returns to 1092, gravity to 0.
module rigid_body_euler_integrator_unit import rbei_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // fields from bit 0: position, lin_vel, ang_vel,
  // orientation, lin_damp, ang_damp, zero padding
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [0:0]            s_tuser,   // bit 0: is_dynamic
  // fields from bit 0: new_position, new_lin_vel,
  // new_ang_vel, new_orientation, zero padding
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]            m_tuser,   // bit 0: saturated, bit 1: norm_too_small
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                   en;
  logic [PIPE_DEPTH:1]    vld;
  logic [STEP_W-1:0]      step_time;
  logic [VEC_BITS-1:0]    gravity_vector;
  logic signed [STEP_W:0] step_s;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign cfg_ready = 1'b1;
  assign m_tvalid = vld[PIPE_DEPTH];
  assign step_s   = $signed({1'b0, step_time});

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time      <= STEP_RESET;
      gravity_vector <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_STEP_TIME) begin
        step_time <= cfg_data[STEP_W-1:0];
      end else if (cfg_index == REG_GRAVITY_VECTOR) begin
        gravity_vector <= cfg_data;
      end
    end
  end

  // Valid bits travel alongside the payload
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-1:1], s_tvalid};
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic [3*VEC_BITS-1:0]    s1_vin;
  logic [QUAT_BITS-1:0]     s1_q;
  logic                     s1_dyn;
  logic signed [GS_W-1:0]   s1_gs [3];
  logic signed [LF_W-1:0]   s1_lf, s1_af;
  logic [2*DAMP_W-1:0]      ld_s, ad_s;

  always_comb begin
    ld_s = s_tdata[3*VEC_BITS+QUAT_BITS +: DAMP_W] * step_time;
    ad_s = s_tdata[3*VEC_BITS+QUAT_BITS+DAMP_W +: DAMP_W] * step_time;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_vin <= s_tdata[3*VEC_BITS-1:0];
      s1_q   <= s_tdata[3*VEC_BITS +: QUAT_BITS];
      s1_dyn <= s_tuser[0];
      for (int i = 0; i < 3; i++) begin
        s1_gs[i] <= $signed(gravity_vector[i*VL +: VL]) * step_s;
      end
      s1_lf <= $signed(LF_W'(1) << DAMP_SHIFT) - $signed({2'b00, ld_s});
      s1_af <= $signed(LF_W'(1) << DAMP_SHIFT) - $signed({2'b00, ad_s});
    end
  end

  // ---------------------------------------------------------------- stage 2
  // velocity plus gravity step; angular rate times damping factor
  logic [3*VEC_BITS-1:0]    s2_vin;
  logic [QUAT_BITS-1:0]     s2_q;
  logic                     s2_dyn;
  logic signed [LF_W-1:0]   s2_lf;
  logic signed [V1_W-1:0]   s2_v1 [3];
  logic signed [WP_W-1:0]   s2_wp [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s2_vin <= s1_vin;
      s2_q   <= s1_q;
      s2_dyn <= s1_dyn;
      s2_lf  <= s1_lf;
      for (int i = 0; i < 3; i++) begin
        s2_v1[i] <= V1_W'($signed(s1_vin[(3+i)*VL +: VL]))
                  + V1_W'(rnd_shift(64'(s1_gs[i]), SF));
        s2_wp[i] <= $signed(s1_vin[(6+i)*VL +: VL]) * s1_af;
      end
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [3*VEC_BITS-1:0]    s3_vin;
  logic [QUAT_BITS-1:0]     s3_q;
  logic                     s3_dyn;
  logic                     s3_sat;
  logic signed [VP_W-1:0]   s3_vp [3];
  logic signed [VL-1:0]     s3_w2 [3];
  logic signed [63:0]       w2_r [3];
  logic signed [63:0]       w2_c [3];
  logic                     w2_sat;

  always_comb begin
    w2_sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      w2_r[i] = rnd_shift(64'(s2_wp[i]), DAMP_SHIFT);
      w2_c[i] = sat_to(w2_r[i], VL);
      w2_sat  = w2_sat | (w2_r[i] != w2_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_vin <= s2_vin;
      s3_q   <= s2_q;
      s3_dyn <= s2_dyn;
      s3_sat <= w2_sat;
      for (int i = 0; i < 3; i++) begin
        s3_vp[i] <= s2_v1[i] * s2_lf;
        s3_w2[i] <= VL'(w2_c[i]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 4
  // damped velocity; omega times quaternion lane products
  logic [3*VEC_BITS-1:0]    s4_vin;
  logic [QUAT_BITS-1:0]     s4_q;
  logic                     s4_dyn;
  logic                     s4_sat;
  logic signed [VL-1:0]     s4_v2 [3];
  logic signed [VL-1:0]     s4_w2 [3];
  logic signed [QP_W-1:0]   s4_qp [3][4];
  logic signed [63:0]       v2_r [3];
  logic signed [63:0]       v2_c [3];
  logic                     v2_sat;

  always_comb begin
    v2_sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      v2_r[i] = rnd_shift(64'(s3_vp[i]), DAMP_SHIFT);
      v2_c[i] = sat_to(v2_r[i], VL);
      v2_sat  = v2_sat | (v2_r[i] != v2_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_vin <= s3_vin;
      s4_q   <= s3_q;
      s4_dyn <= s3_dyn;
      s4_sat <= s3_sat | v2_sat;
      for (int i = 0; i < 3; i++) begin
        s4_v2[i] <= VL'(v2_c[i]);
        s4_w2[i] <= s3_w2[i];
        for (int j = 0; j < 4; j++) begin
          s4_qp[i][j] <= s3_w2[i] * $signed(s3_q[j*QL +: QL]);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 5
  // velocity times step; Hamilton product sums
  logic [3*VEC_BITS-1:0]    s5_vin;
  logic [QUAT_BITS-1:0]     s5_q;
  logic                     s5_dyn;
  logic                     s5_sat;
  logic signed [VL-1:0]     s5_v2 [3];
  logic signed [VL-1:0]     s5_w2 [3];
  logic signed [GS_W-1:0]   s5_ps [3];
  logic signed [D_W-1:0]    s5_d [4];

  always_ff @(posedge clk) begin
    if (en) begin
      s5_vin <= s4_vin;
      s5_q   <= s4_q;
      s5_dyn <= s4_dyn;
      s5_sat <= s4_sat;
      for (int i = 0; i < 3; i++) begin
        s5_v2[i] <= s4_v2[i];
        s5_w2[i] <= s4_w2[i];
        s5_ps[i] <= s4_v2[i] * step_s;
      end
      s5_d[0] <= D_W'(s4_qp[0][3]) + D_W'(s4_qp[1][2]) - D_W'(s4_qp[2][1]);
      s5_d[1] <= D_W'(s4_qp[1][3]) + D_W'(s4_qp[2][0]) - D_W'(s4_qp[0][2]);
      s5_d[2] <= D_W'(s4_qp[0][1]) - D_W'(s4_qp[1][0]) + D_W'(s4_qp[2][3]);
      s5_d[3] <= -(D_W'(s4_qp[0][0]) + D_W'(s4_qp[1][1]) + D_W'(s4_qp[2][2]));
    end
  end

  // ---------------------------------------------------------------- stage 6
  // new position; quaternion derivative times step; vector results chosen
  logic [QUAT_BITS-1:0]     s6_q;
  logic                     s6_dyn;
  logic                     s6_sat;
  logic [3*VEC_BITS-1:0]    s6_vout;
  logic signed [DS_W-1:0]   s6_ds [4];
  logic signed [63:0]       p2_r [3];
  logic signed [63:0]       p2_c [3];
  logic                     p2_sat;
  logic [3*VEC_BITS-1:0]    vout_dyn;

  always_comb begin
    p2_sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      p2_r[i] = 64'($signed(s5_vin[i*VL +: VL])) + rnd_shift(64'(s5_ps[i]), SF);
      p2_c[i] = sat_to(p2_r[i], VL);
      p2_sat  = p2_sat | (p2_r[i] != p2_c[i]);
      vout_dyn[i*VL +: VL]     = VL'(p2_c[i]);
      vout_dyn[(3+i)*VL +: VL] = s5_v2[i];
      vout_dyn[(6+i)*VL +: VL] = s5_w2[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_q    <= s5_q;
      s6_dyn  <= s5_dyn;
      s6_sat  <= s5_sat | p2_sat;
      s6_vout <= s5_dyn ? vout_dyn : s5_vin;
      for (int k = 0; k < 4; k++) begin
        s6_ds[k] <= s5_d[k] * step_s;
      end
    end
  end

  // ---------------------------------------------------------------- stage 7
  // integrated quaternion lanes
  carry_t c7;

  always_ff @(posedge clk) begin
    if (en) begin
      c7.dyn  <= s6_dyn;
      c7.satf <= s6_sat;
      c7.tiny <= 1'b0;
      c7.e    <= '0;
      c7.vout <= s6_vout;
      for (int k = 0; k < 4; k++) begin
        if (s6_dyn) begin
          c7.qn[k] <= QN_W'($signed(s6_q[k*QL +: QL]))
                    + QN_W'(rnd_shift(64'(s6_ds[k]), HALF_STEP_SHIFT));
        end else begin
          c7.qn[k] <= QN_W'($signed(s6_q[k*QL +: QL]));
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 8
  carry_t            c8;
  logic [SQ_W-1:0]   s8_sq [4];

  always_ff @(posedge clk) begin
    if (en) begin
      c8 <= c7;
      for (int k = 0; k < 4; k++) begin
        s8_sq[k] <= SQ_W'($signed(c7.qn[k]) * $signed(c7.qn[k]));
      end
    end
  end

  // ---------------------------------------------------------------- stage 9
  carry_t            c9;
  logic [N2_W-1:0]   s9_n2;

  always_ff @(posedge clk) begin
    if (en) begin
      c9    <= c8;
      s9_n2 <= N2_W'(s8_sq[0]) + N2_W'(s8_sq[1]) + N2_W'(s8_sq[2]) + N2_W'(s8_sq[3]);
    end
  end

  // ---------------------------------------------------------------- stage 10
  // tiny-norm test and normalising exponent (smallest even shift to 2^60)
  carry_t            c10;
  carry_t            c10_next;
  logic [N2_W-1:0]   s10_n2;
  logic [E_W-1:0]    e_sel;

  always_comb begin
    e_sel = '0;
    for (int k = E_MAX; k >= 0; k--) begin
      if (s9_n2 >= (N2_W'(1) << (NORM_LOG2 - 2 * k))) e_sel = E_W'(k);
    end
    c10_next      = c9;
    c10_next.tiny = s9_n2 < TINY_LIMIT;
    c10_next.e    = e_sel;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c10    <= c10_next;
      s10_n2 <= s9_n2;
    end
  end

  // ---------------------------------------------------------------- stage 11
  // scaled squared norm enters the square root pipeline
  carry_t            sq_c    [RT_W+1];
  logic [N2_W-1:0]   sq_rem  [RT_W+1];
  logic [RT_W-1:0]   sq_root [RT_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_c[0]    <= c10;
      sq_rem[0]  <= s10_n2 << (2 * c10.e);
      sq_root[0] <= '0;
    end
  end

  // Square root, one result bit per stage
  for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
    localparam int B = RT_W - 1 - k;
    logic [N2_W+1:0] sub;
    logic [N2_W+1:0] trial;

    always_comb begin
      sub   = ((N2_W+2)'(sq_root[k]) << (B + 1)) + ((N2_W+2)'(1) << (2 * B));
      trial = {2'b00, sq_rem[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_c[k+1] <= sq_c[k];
        if (trial >= sub) begin
          sq_rem[k+1]  <= N2_W'(trial - sub);
          sq_root[k+1] <= sq_root[k] | (RT_W'(1) << B);
        end else begin
          sq_rem[k+1]  <= sq_rem[k];
          sq_root[k+1] <= sq_root[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------- divider set-up
  // dividend = |q| << (frac + e) plus half the root for rounding
  carry_t             dv_c   [QT_W+1];
  logic [RT_W-1:0]    dv_s   [QT_W+1];
  logic [NUM_W-1:0]   dv_num [QT_W+1][4];
  logic [DREM_W-1:0]  dv_rem [QT_W+1][4];
  logic [QT_W-1:0]    dv_q   [QT_W+1][4];
  logic [QN_W-1:0]    q_mag  [4];
  logic [NUM_W-1:0]   num0   [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      q_mag[l] = sq_c[RT_W].qn[l][QN_W-1] ? (QN_W'(0) - sq_c[RT_W].qn[l])
                                           : sq_c[RT_W].qn[l];
      num0[l]  = NUM_W'((64'(q_mag[l]) << (QF + sq_c[RT_W].e))
                        + 64'(sq_root[RT_W] >> 1));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_c[0] <= sq_c[RT_W];
      dv_s[0] <= sq_root[RT_W];
      for (int l = 0; l < 4; l++) begin
        dv_num[0][l] <= num0[l];
        dv_rem[0][l] <= DREM_W'(num0[l] >> QT_W);
        dv_q[0][l]   <= '0;
      end
    end
  end

  // Restoring divider, one quotient bit per stage, four lanes side by side
  for (genvar k = 0; k < QT_W; k++) begin : g_div
    localparam int B = QT_W - 1 - k;
    logic [DREM_W-1:0] t [4];

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        t[l] = {dv_rem[k][l][DREM_W-2:0], dv_num[k][l][B]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_c[k+1] <= dv_c[k];
        dv_s[k+1] <= dv_s[k];
        for (int l = 0; l < 4; l++) begin
          dv_num[k+1][l] <= dv_num[k][l];
          if (t[l] >= {1'b0, dv_s[k]}) begin
            dv_rem[k+1][l] <= t[l] - {1'b0, dv_s[k]};
            dv_q[k+1][l]   <= dv_q[k][l] | (QT_W'(1) << B);
          end else begin
            dv_rem[k+1][l] <= t[l];
            dv_q[k+1][l]   <= dv_q[k][l];
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- output register
  carry_t              fc;
  logic [QUAT_BITS-1:0] oq;
  logic                q_sat;
  logic signed [63:0]  qv [4];
  logic signed [63:0]  qc [4];

  assign fc = dv_c[QT_W];

  always_comb begin
    q_sat = 1'b0;
    for (int l = 0; l < 4; l++) begin
      if (!fc.dyn || fc.tiny) begin
        qv[l] = 64'($signed(fc.qn[l]));
      end else if (fc.qn[l][QN_W-1]) begin
        qv[l] = -$signed(64'(dv_q[QT_W][l]));
      end else begin
        qv[l] = $signed(64'(dv_q[QT_W][l]));
      end
      qc[l] = sat_to(qv[l], QL);
      q_sat = q_sat | (qc[l] != qv[l]);
      oq[l*QL +: QL] = QL'(qc[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata    <= OUT_DATA_W'({oq, fc.vout});
      m_tuser[0] <= fc.dyn & (fc.satf | q_sat);
      m_tuser[1] <= fc.dyn & fc.tiny;
    end
  end

endmodule

// ===== design/rbei_checker.sv =====
// Port-level checks for the rigid body integrator, bound to the top level.
module rbei_checker import rbei_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]            m_tuser
);

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // input side moves exactly when the output register can move
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready out of step with output stall");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // padding above the packed lanes stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_FIELD_BITS] == '0)
    else $error("nonzero output padding");

endmodule

bind rigid_body_euler_integrator_unit rbei_checker u_rbei_checker (.*);
